// ===== design/tnc_pkg.sv =====
// Shared widths and command codes for the triangle normal and centroid block.
package tnc_pkg;

  localparam int CW    = 24;   // coordinate width inside the datapath
  localparam int IDXW  = 10;   // vertex index and corner fields
  localparam int TAGW  = 16;
  localparam int EW    = 26;   // multiplier operand width
  localparam int PW    = 2 * EW;
  localparam int CRW   = 51;   // cross product component
  localparam int SUMW  = 102;  // sum of squares, even width for the root
  localparam int ROOTW = SUMW / 2;
  localparam int NW    = 18;   // unit normal component, Q1.16
  localparam int QW    = 17;   // normal quotient magnitude
  localparam int CSW   = 26;   // centroid coordinate sum
  localparam int TDW   = 29;   // offset sum fed to the divide by three
  localparam int SPLIT = 25;   // low half of a magnitude for squaring

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

endpackage

// ===== design/tnc_if.sv =====
// Channel interfaces: input word and result word with valid/ready.
interface tnc_in_if;
  import tnc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [IDXW-1:0]        vertex_index;
  logic signed [CW-1:0]   coord_x;
  logic signed [CW-1:0]   coord_y;
  logic signed [CW-1:0]   coord_z;
  logic [IDXW-1:0]        corner_a;
  logic [IDXW-1:0]        corner_b;
  logic [IDXW-1:0]        corner_c;
  logic [TAGW-1:0]        triangle_id;
  modport source (output valid, command, vertex_index, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, triangle_id, input ready);
  modport sink (input valid, command, vertex_index, coord_x, coord_y, coord_z,
                corner_a, corner_b, corner_c, triangle_id, output ready);
endinterface

interface tnc_out_if;
  import tnc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [TAGW-1:0]        result_tag;
  logic signed [NW-1:0]   normal_x;
  logic signed [NW-1:0]   normal_y;
  logic signed [NW-1:0]   normal_z;
  logic [ROOTW-1:0]       cross_magnitude;
  logic signed [CW-1:0]   centroid_x;
  logic signed [CW-1:0]   centroid_y;
  logic signed [CW-1:0]   centroid_z;
  modport source (output valid, result_tag, normal_x, normal_y, normal_z,
                  cross_magnitude, centroid_x, centroid_y, centroid_z, input ready);
  modport sink (input valid, result_tag, normal_x, normal_y, normal_z,
                cross_magnitude, centroid_x, centroid_y, centroid_z, output ready);
endinterface

// ===== design/tnc_store.sv =====
// Vertex memory: one write port, one registered read port, range check on both.
module tnc_store
  import tnc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 72
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDXW-1:0]  waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [IDXW-1:0]  raddr,
  output logic [WIDTH-1:0] rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic             rd_ok;
  logic [16:0]      wext;
  logic [16:0]      rext;

  assign wext = 17'(waddr);
  assign rext = 17'(raddr);

  always_ff @(posedge clk) begin
    if (we && wext < 17'(DEPTH)) begin
      mem[wext[AW-1:0]] <= wdata;
    end
    rd_q  <= mem[rext[AW-1:0]];
    rd_ok <= rext < 17'(DEPTH);
  end

  // out-of-range corners read as the origin
  assign rdata = rd_ok ? rd_q : '0;
endmodule

// ===== design/tnc_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module tnc_sqrt
  import tnc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUMW-1:0]  radicand,
  output logic             done,
  output logic [ROOTW-1:0] root
);
  localparam int RW = ROOTW + 3;

  logic [SUMW-1:0] sreg;
  logic [RW-1:0]   rem;
  logic [5:0]      cnt;
  logic            busy;
  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   trial;

  assign rem_sh = {rem[RW-3:0], sreg[SUMW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sreg <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (busy) begin
        sreg <= sreg << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOTW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOTW-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(ROOTW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/tnc_div.sv =====
// Three-lane restoring divider: component * 2^16 / magnitude, one quotient bit a cycle.
module tnc_div
  import tnc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [CRW-1:0] comp [3],
  input  logic [ROOTW-1:0]      mag,
  output logic                  done,
  output logic signed [NW-1:0]  normal [3]
);
  localparam int DRW = ROOTW + 2;

  logic [DRW-1:0] r [3];
  logic [QW-1:0]  q [3];
  logic           neg [3];
  logic [ROOTW-1:0] m;
  logic [4:0]     cnt;
  logic           busy;
  logic [DRW-1:0] rr [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rr[k] = (cnt == 5'd0) ? r[k] : {r[k][DRW-2:0], 1'b0};
      normal[k] = neg[k] ? -NW'(q[k]) : NW'(q[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        m    <= mag;
        for (int k = 0; k < 3; k++) begin
          neg[k] <= comp[k][CRW-1];
          r[k]   <= DRW'(comp[k][CRW-1] ? -comp[k] : comp[k]);
          q[k]   <= '0;
        end
      end else if (busy) begin
        for (int k = 0; k < 3; k++) begin
          if (rr[k] >= DRW'(m)) begin
            r[k] <= rr[k] - DRW'(m);
            q[k] <= {q[k][QW-2:0], 1'b1};
          end else begin
            r[k] <= rr[k];
            q[k] <= {q[k][QW-2:0], 1'b0};
          end
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/tnc_third.sv =====
// Three-lane bit-serial divide by three with round to nearest, for the centroid.
module tnc_third
  import tnc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [CSW-1:0] sum [3],
  output logic                  busy,
  output logic signed [CW-1:0]  mean [3]
);
  // bias keeps sum+1 nonnegative; its quotient has no low bits set
  localparam logic [TDW-1:0] BIAS = TDW'(3) << (CSW);

  logic [TDW-1:0] u [3];
  logic [1:0]     rem [3];
  logic [CW-1:0]  q [3];
  logic [4:0]     cnt;
  logic [2:0]     rs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs[k]   = {rem[k], u[k][TDW-1]};
      mean[k] = q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      for (int k = 0; k < 3; k++) begin
        u[k]   <= TDW'(sum[k]) + TDW'(1) + BIAS;
        rem[k] <= '0;
      end
    end else if (busy) begin
      for (int k = 0; k < 3; k++) begin
        u[k] <= u[k] << 1;
        if (rs[k] >= 3'd3) begin
          rem[k] <= 2'(rs[k] - 3'd3);
          q[k]   <= {q[k][CW-2:0], 1'b1};
        end else begin
          rem[k] <= rs[k][1:0];
          q[k]   <= {q[k][CW-2:0], 1'b0};
        end
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'(TDW - 1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ===== design/triangle_normal_and_centroid.sv =====
// Top level: vertex store, cross product sequencer, root, divider and centroid.
//
//  channel  dir  word                                          accepted
//  in_ch    in   command, index, x/y/z, corners a/b/c, tag     valid && ready
//  out_ch   out  tag, normal x/y/z, magnitude, centroid x/y/z  valid && ready
//
// A compute word is not accepted until the previous one leaves the sequencer:
// the four load states, one edge state, 16 multiplier steps, the 51 square
// root steps, the 17 divider steps and the output load; a degenerate
// triangle skips the divider.
// Reset clears control only; the store holds garbage until written.
// A finished result sits in the output register; the next word is taken
// while it waits, and a second result stalls in the final state.
module triangle_normal_and_centroid
  import tnc_pkg::*;
#(
  parameter int VERTEX_DEPTH = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic     clk,
  input  logic     rst,
  tnc_in_if.sink   in_ch,
  tnc_out_if.source out_ch
);
  localparam int VW = 3 * COORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_LD0, S_LD1, S_LD2, S_LD3, S_EDGE, S_MUL, S_SQRT, S_DIV, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_SET, OP_SUB, OP_SQ0, OP_SQ1, OP_SQ2
  } op_t;

  state_t state;

  logic [IDXW-1:0] ca, cb, cc;
  logic [TAGW-1:0] tag;
  logic signed [CW-1:0]  va [3];
  logic signed [CW-1:0]  vb [3];
  logic signed [CW-1:0]  vc [3];
  logic signed [CW-1:0]  rv [3];
  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [CSW-1:0] csum [3];
  logic signed [CRW-1:0] cr [3];
  logic [SUMW-1:0]       sq;
  logic [3:0]            step;
  op_t                   acc_op;
  logic [1:0]            acc_j;
  logic signed [PW-1:0]  prod;
  logic                  go_root;
  logic                  go_div;

  logic signed [EW-1:0]  mul_a, mul_b;
  op_t                   op;
  logic [1:0]            op_j;
  logic [1:0]            sq_j;
  logic [CRW-1:0]        sq_abs;
  logic signed [EW-1:0]  ml, mh;

  logic                  we;
  logic [IDXW-1:0]       raddr;
  logic [VW-1:0]         rdata;
  logic signed [COORD_BITS-1:0] rc [3];
  logic signed [COORD_BITS-1:0] wc [3];

  logic                  sqrt_done;
  logic [ROOTW-1:0]      root;
  logic                  div_done;
  logic signed [NW-1:0]  normal [3];
  logic                  third_busy;
  logic signed [CW-1:0]  mean [3];

  logic                  out_valid;
  logic [TAGW-1:0]       o_tag;
  logic signed [NW-1:0]  o_n [3];
  logic [ROOTW-1:0]      o_mag;
  logic signed [CW-1:0]  o_c [3];
  logic [ROOTW-1:0]      mag;
  logic signed [NW-1:0]  nrm [3];

  assign in_ch.ready = (state == S_IDLE);
  assign we = in_ch.valid && in_ch.ready && in_ch.command == CMD_WRITE;

  assign wc[0] = in_ch.coord_x[COORD_BITS-1:0];
  assign wc[1] = in_ch.coord_y[COORD_BITS-1:0];
  assign wc[2] = in_ch.coord_z[COORD_BITS-1:0];

  always_comb begin
    case (state)
      S_LD1:   raddr = cb;
      S_LD2:   raddr = cc;
      default: raddr = ca;
    endcase
    for (int k = 0; k < 3; k++) begin
      rc[k] = rdata[k*COORD_BITS +: COORD_BITS];
      rv[k] = CW'(rc[k]);
    end
  end

  tnc_store #(.DEPTH(VERTEX_DEPTH), .WIDTH(VW)) u_store (
    .clk, .we, .waddr(in_ch.vertex_index), .wdata({wc[2], wc[1], wc[0]}),
    .raddr, .rdata
  );

  // multiplier schedule: six cross terms, then three partial squares per component
  always_comb begin
    case (step)
      4'd9, 4'd10, 4'd11:  sq_j = 2'd1;
      4'd12, 4'd13, 4'd14: sq_j = 2'd2;
      default:             sq_j = 2'd0;
    endcase
    sq_abs = cr[sq_j][CRW-1] ? CRW'(-cr[sq_j]) : CRW'(cr[sq_j]);
    ml = EW'(sq_abs[SPLIT-1:0]);
    mh = EW'(sq_abs[2*SPLIT-1:SPLIT]);
    mul_a = '0;
    mul_b = '0;
    op    = OP_NONE;
    op_j  = 2'd0;
    case (step)
      4'd0: begin mul_a = e1[1]; mul_b = e2[2]; op = OP_SET; op_j = 2'd0; end
      4'd1: begin mul_a = e1[2]; mul_b = e2[1]; op = OP_SUB; op_j = 2'd0; end
      4'd2: begin mul_a = e1[2]; mul_b = e2[0]; op = OP_SET; op_j = 2'd1; end
      4'd3: begin mul_a = e1[0]; mul_b = e2[2]; op = OP_SUB; op_j = 2'd1; end
      4'd4: begin mul_a = e1[0]; mul_b = e2[1]; op = OP_SET; op_j = 2'd2; end
      4'd5: begin mul_a = e1[1]; mul_b = e2[0]; op = OP_SUB; op_j = 2'd2; end
      4'd6, 4'd9, 4'd12: begin mul_a = ml; mul_b = ml; op = OP_SQ0; end
      4'd7, 4'd10, 4'd13: begin mul_a = mh; mul_b = ml; op = OP_SQ1; end
      4'd8, 4'd11, 4'd14: begin mul_a = mh; mul_b = mh; op = OP_SQ2; end
      default: ;
    endcase
  end

  tnc_sqrt u_sqrt (
    .clk, .rst, .start(go_root), .radicand(sq), .done(sqrt_done), .root
  );

  tnc_third u_third (
    .clk, .rst, .start(go_root), .sum(csum), .busy(third_busy), .mean
  );

  tnc_div u_div (
    .clk, .rst, .start(go_div), .comp(cr), .mag, .done(div_done), .normal
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      go_root   <= 1'b0;
      go_div    <= 1'b0;
      acc_op    <= OP_NONE;
    end else begin
      go_root <= 1'b0;
      go_div  <= 1'b0;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      prod   <= mul_a * mul_b;
      acc_op <= (state == S_MUL) ? op : OP_NONE;
      acc_j  <= op_j;
      case (acc_op)
        OP_SET:  cr[acc_j] <= CRW'(prod);
        OP_SUB:  cr[acc_j] <= cr[acc_j] - CRW'(prod);
        OP_SQ0:  sq <= sq + SUMW'($unsigned(prod));
        OP_SQ1:  sq <= sq + (SUMW'($unsigned(prod)) << (SPLIT + 1));
        OP_SQ2:  sq <= sq + (SUMW'($unsigned(prod)) << (2 * SPLIT));
        default: ;
      endcase

      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.command == CMD_COMPUTE) begin
            ca    <= in_ch.corner_a;
            cb    <= in_ch.corner_b;
            cc    <= in_ch.corner_c;
            tag   <= in_ch.triangle_id;
            state <= S_LD0;
          end
        end
        S_LD0: state <= S_LD1;
        S_LD1: begin
          va    <= rv;
          state <= S_LD2;
        end
        S_LD2: begin
          vb    <= rv;
          state <= S_LD3;
        end
        S_LD3: begin
          vc    <= rv;
          state <= S_EDGE;
        end
        S_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            e1[k]   <= EW'(vb[k]) - EW'(va[k]);
            e2[k]   <= EW'(vc[k]) - EW'(va[k]);
            csum[k] <= CSW'(va[k]) + CSW'(vb[k]) + CSW'(vc[k]);
          end
          sq    <= '0;
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 4'd1;
          if (step == 4'd15) begin
            go_root <= 1'b1;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            mag <= root;
            if (root == '0) begin
              for (int k = 0; k < 3; k++) nrm[k] <= '0;
              state <= S_DONE;
            end else begin
              go_div <= 1'b1;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            nrm   <= normal;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            o_tag     <= tag;
            o_n       <= nrm;
            o_mag     <= mag;
            o_c       <= mean;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.result_tag      = o_tag;
  assign out_ch.normal_x        = o_n[0];
  assign out_ch.normal_y        = o_n[1];
  assign out_ch.normal_z        = o_n[2];
  assign out_ch.cross_magnitude = o_mag;
  assign out_ch.centroid_x      = o_c[0];
  assign out_ch.centroid_y      = o_c[1];
  assign out_ch.centroid_z      = o_c[2];

  a_root_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_SQRT)
    else $error("root finished outside the root phase");

  a_third_ready: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> !third_busy)
    else $error("centroid still busy when root finished");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && o_mag == '0 |-> o_n[0] == '0 && o_n[1] == '0 && o_n[2] == '0)
    else $error("degenerate triangle with nonzero normal");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !out_ch.ready |=> state == S_DONE)
    else $error("result dropped while output register was full");
endmodule
